@@ hw/rtl/dd_pkg.sv @@
package dd_pkg;

  // Fixed field widths of the two channels
  localparam int OPCODE_W = 3;
  localparam int PIDX_W   = 3;
  localparam int RIDX_W   = 2;
  localparam int AMOUNT_W = 16;
  localparam int MASK_W   = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCS_IN_USE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCES_IN_USE = 2'd1;

  localparam logic [3:0] PROCS_IN_USE_RESET     = 4'd8;
  localparam logic [2:0] RESOURCES_IN_USE_RESET = 3'd4;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_LOAD_EXISTING  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD_AVAILABLE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LOAD_ALLOC     = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_LOAD_REQUEST   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RUN            = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PIDX_W-1:0]   proc_index;
    logic [RIDX_W-1:0]   resource_index;
    logic [AMOUNT_W-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic              deadlocked;
    logic [MASK_W-1:0] stuck_mask;
    logic [MASK_W-1:0] impossible_mask;
  } out_item_t;

endpackage

@@ hw/rtl/deadlock_detection.sv @@
// Channel   Handshake              Payload                   Direction
// in_       in_valid / in_ready    dd_pkg::in_item_t         input
// out_      out_valid / out_ready  dd_pkg::out_item_t        output
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data       input
//
// A load is written as it is taken; the next item is taken in the following cycle.
// A run scans each process and resource for impossibility (request plus alloc
// above existing), then makes passes: finished and impossible processes are
// skipped without a read, the rest checked against work, and each that can
// finish adds its allocation to work; at most P+1 passes (P = processes in use)
// before the result is loaded. Every compare and add uses one shared saturating
// adder and comparator, fed by the single registered read port of both memories.
// Reset (rst_n low, synchronous) idles the sequencer and drops any held result.
// A finished result waits in the output register; the sequencer holds until it is free.
module deadlock_detection #(
  parameter int MAX_PROCS     = 8,
  parameter int MAX_RESOURCES = 4,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  dd_pkg::in_item_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output dd_pkg::out_item_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PIW   = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int DEPTH = MAX_PROCS * MAX_RESOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_IMP  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [PIW-1:0]          i_r, i_nxt;
  logic [RIW-1:0]          k_r, k_nxt;
  logic                    ph_r, ph_nxt;
  logic                    fail_r, fail_nxt;
  logic                    prog_r, prog_nxt;
  logic [MAX_PROCS-1:0]    imp_r, imp_nxt;
  logic [MAX_PROCS-1:0]    done_r, done_nxt;
  logic [COUNT_WIDTH-1:0]  work_r [MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0]  work_nxt [MAX_RESOURCES];
  logic                    out_valid_r, out_valid_nxt;
  dd_pkg::out_item_t       out_r, out_nxt;
  logic [3:0]              procs_r, procs_nxt;
  logic [2:0]              res_r, res_nxt;

  logic [COUNT_WIDTH-1:0]  existing_r [MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0]  avail_r [MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0]  alloc_mem [DEPTH];
  logic [COUNT_WIDTH-1:0]  req_mem [DEPTH];
  logic [COUNT_WIDTH-1:0]  alloc_q, req_q;

  logic                    in_acc, run_acc;
  logic                    p_ok, r_ok;
  logic                    we_exist, we_avail, we_alloc, we_req;
  logic [COUNT_WIDTH-1:0]  amt_c;
  logic [RIW-1:0]          wr_ridx;
  logic [AW-1:0]           waddr, raddr;

  logic [31:0]             np_lim, nr_lim;
  logic                    i_last, k_last;
  logic [MAX_PROCS-1:0]    inuse, stuck;

  logic [COUNT_WIDTH-1:0]  sum_a, sum_sat, cmp_a, cmp_b;
  logic [COUNT_WIDTH:0]    sum_raw;
  logic                    gt;
  logic                    adv, adv_prog;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_acc  = in_valid && in_ready;
  assign run_acc = in_acc && (in_data.opcode == dd_pkg::OP_RUN);

  // ---------------------------------------------------------------------------
  // Load decode: drop loads whose index is outside the stores
  // ---------------------------------------------------------------------------
  assign p_ok    = (32'(in_data.proc_index) < MAX_PROCS);
  assign r_ok    = (32'(in_data.resource_index) < MAX_RESOURCES);
  assign amt_c   = COUNT_WIDTH'(in_data.amount);
  assign wr_ridx = RIW'(in_data.resource_index);
  assign waddr   = AW'(32'(in_data.proc_index) * MAX_RESOURCES
                       + 32'(in_data.resource_index));

  always_comb begin
    we_exist = 1'b0;
    we_avail = 1'b0;
    we_alloc = 1'b0;
    we_req   = 1'b0;
    unique case (in_data.opcode)
      dd_pkg::OP_LOAD_EXISTING:  we_exist = in_acc && r_ok;
      dd_pkg::OP_LOAD_AVAILABLE: we_avail = in_acc && r_ok;
      dd_pkg::OP_LOAD_ALLOC:     we_alloc = in_acc && r_ok && p_ok;
      dd_pkg::OP_LOAD_REQUEST:   we_req   = in_acc && r_ok && p_ok;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Effective counts: zero counts as one, clamp to the store size
  // ---------------------------------------------------------------------------
  assign np_lim = (procs_r == '0) ? 32'd1 :
                  ((32'(procs_r) > MAX_PROCS) ? 32'(MAX_PROCS) : 32'(procs_r));
  assign nr_lim = (res_r == '0) ? 32'd1 :
                  ((32'(res_r) > MAX_RESOURCES) ? 32'(MAX_RESOURCES) : 32'(res_r));

  assign i_last = (32'(i_r) + 32'd1 == np_lim);
  assign k_last = (32'(k_r) + 32'd1 == nr_lim);

  always_comb begin
    for (int p = 0; p < MAX_PROCS; p++) begin
      inuse[p] = (32'(p) < np_lim);
    end
  end

  assign stuck = inuse & ~done_r;

  // ---------------------------------------------------------------------------
  // Matrix read address follows the sequencer; the registered read data arrives later
  // ---------------------------------------------------------------------------
  assign raddr = AW'(32'(i_r) * MAX_RESOURCES + 32'(k_r));

  // ---------------------------------------------------------------------------
  // Shared saturating adder and comparator
  //   scan:  (request + alloc) > existing
  //   check: request > work
  //   add:   work + alloc
  // ---------------------------------------------------------------------------
  assign sum_a   = (state_r == ST_IMP) ? req_q : work_r[k_r];
  assign sum_raw = {1'b0, sum_a} + {1'b0, alloc_q};
  assign sum_sat = sum_raw[COUNT_WIDTH] ? '1 : sum_raw[COUNT_WIDTH-1:0];
  assign cmp_a   = (state_r == ST_IMP) ? sum_sat : req_q;
  assign cmp_b   = (state_r == ST_IMP) ? existing_r[k_r] : work_r[k_r];
  assign gt      = (cmp_a > cmp_b);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    ph_nxt        = ph_r;
    fail_nxt      = fail_r;
    prog_nxt      = prog_r;
    imp_nxt       = imp_r;
    done_nxt      = done_r;
    work_nxt      = work_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    procs_nxt     = procs_r;
    res_nxt       = res_r;
    adv           = 1'b0;
    adv_prog      = prog_r;

    // Drop the held result once it has been transferred
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == dd_pkg::CFG_PROCS_IN_USE) begin
        procs_nxt = cfg_data[3:0];
      end else if (cfg_index == dd_pkg::CFG_RESOURCES_IN_USE) begin
        res_nxt = cfg_data[2:0];
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (run_acc) begin
          imp_nxt   = '0;
          done_nxt  = '0;
          i_nxt     = '0;
          k_nxt     = '0;
          ph_nxt    = 1'b0;
          fail_nxt  = 1'b0;
          prog_nxt  = 1'b0;
          work_nxt  = avail_r;
          state_nxt = ST_IMP;
        end
      end

      ST_IMP: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (gt) begin
            imp_nxt[i_r] = 1'b1;
          end
          if (k_last) begin
            k_nxt = '0;
            if (i_last) begin
              i_nxt     = '0;
              state_nxt = ST_CHK;
            end else begin
              i_nxt = i_r + PIW'(1);
            end
          end else begin
            k_nxt = k_r + RIW'(1);
          end
        end
      end

      ST_CHK: begin
        if (!ph_r) begin
          // Skip finished and impossible processes without a read
          if (imp_r[i_r] || done_r[i_r]) begin
            adv = 1'b1;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          ph_nxt = 1'b0;
          if (k_last) begin
            k_nxt    = '0;
            fail_nxt = 1'b0;
            if (!(fail_r || gt)) begin
              state_nxt = ST_ADD;
            end else begin
              adv = 1'b1;
            end
          end else begin
            k_nxt    = k_r + RIW'(1);
            fail_nxt = fail_r || gt;
          end
        end
      end

      ST_ADD: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt        = 1'b0;
          work_nxt[k_r] = sum_sat;
          if (k_last) begin
            k_nxt         = '0;
            done_nxt[i_r] = 1'b1;
            adv           = 1'b1;
            adv_prog      = 1'b1;
          end else begin
            k_nxt = k_r + RIW'(1);
          end
        end
      end

      ST_FIN: begin
        // Hold here until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_nxt.deadlocked      = |stuck;
          out_nxt.stuck_mask      = dd_pkg::MASK_W'(stuck);
          out_nxt.impossible_mask = dd_pkg::MASK_W'(imp_r);
          state_nxt               = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Advance to the next process; after the last one, start another pass
    // only if this pass finished something
    if (adv) begin
      if (i_last) begin
        i_nxt = '0;
        if (adv_prog) begin
          prog_nxt  = 1'b0;
          state_nxt = ST_CHK;
        end else begin
          state_nxt = ST_FIN;
        end
      end else begin
        i_nxt     = i_r + PIW'(1);
        prog_nxt  = adv_prog;
        state_nxt = ST_CHK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      k_r         <= '0;
      ph_r        <= 1'b0;
      fail_r      <= 1'b0;
      prog_r      <= 1'b0;
      imp_r       <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
      procs_r     <= dd_pkg::PROCS_IN_USE_RESET;
      res_r       <= dd_pkg::RESOURCES_IN_USE_RESET;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      k_r         <= k_nxt;
      ph_r        <= ph_nxt;
      fail_r      <= fail_nxt;
      prog_r      <= prog_nxt;
      imp_r       <= imp_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      procs_r     <= procs_nxt;
      res_r       <= res_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    out_r  <= out_nxt;
    if (we_exist) begin
      existing_r[wr_ridx] <= amt_c;
    end
    if (we_avail) begin
      avail_r[wr_ridx] <= amt_c;
    end
  end

  // Allocation and request memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_alloc) begin
      alloc_mem[waddr] <= amt_c;
    end
    if (we_req) begin
      req_mem[waddr] <= amt_c;
    end
    alloc_q <= alloc_mem[raddr];
    req_q   <= req_mem[raddr];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_run_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    run_acc |=> (state_r == ST_IMP) && (done_r == '0) && (imp_r == '0))
    else $error("run transfer did not start the impossibility scan");

  a_imp_never_done: assert property (@(posedge clk) disable iff (!rst_n)
    (imp_r & done_r) == '0)
    else $error("impossible process marked finished");

  a_done_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ((done_r & ~inuse) == '0))
    else $error("process outside the in-use set finished");

  a_imp_subset_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.impossible_mask & ~out_r.stuck_mask) == '0))
    else $error("impossible process reported as not stuck");

endmodule
